// ===== sv/pdist_pkg.sv =====
// Shared constants for the polyline point distance block.
package pdist_pkg;

	localparam int DIST_BITS = 25;
	localparam int MIN_BITS  = 26;
	localparam int OUT_TDATA_BITS = ((DIST_BITS + 7) / 8) * 8;

	localparam logic [DIST_BITS-1:0] DIST_SAT  = 25'h1FFFFFF;
	localparam logic [MIN_BITS-1:0]  MIN_RESET = 26'h3FFFFFF;

endpackage

// ===== sv/pdist_front.sv =====
// Front end: classifies a segment request and builds a Bresenham walk command.
module pdist_front #(
	parameter int COORD_BITS = 12,
	parameter int CMD_BITS   = 8 * COORD_BITS + 12
) (
	input  logic signed [COORD_BITS-1:0] seg_x0,
	input  logic signed [COORD_BITS-1:0] seg_y0,
	input  logic signed [COORD_BITS-1:0] seg_x1,
	input  logic signed [COORD_BITS-1:0] seg_y1,
	input  logic signed [COORD_BITS-1:0] probe_x,
	input  logic signed [COORD_BITS-1:0] probe_y,
	input  logic                         last_segment,
	output logic [CMD_BITS-1:0]          cmd
);

	localparam int CB = COORD_BITS;
	localparam int EW = COORD_BITS + 3;

	logic signed [CB:0]   dx, dy, adx, ady;
	logic signed [EW-1:0] adx_e, ady_e, err, incs, incd;
	logic                 xmaj, swap, dir;
	logic signed [CB-1:0] sx, sy;
	logic [CB-1:0]        cnt;

	always_comb begin
		dx    = (CB+1)'(seg_x1) - (CB+1)'(seg_x0);
		dy    = (CB+1)'(seg_y1) - (CB+1)'(seg_y0);
		adx   = (dx < 0) ? -dx : dx;
		ady   = (dy < 0) ? -dy : dy;
		adx_e = EW'(adx);
		ady_e = EW'(ady);
		xmaj  = (ady <= adx);
		if (xmaj) begin
			err  = (ady_e <<< 1) - adx_e;
			incs = ady_e <<< 1;
			incd = (ady_e - adx_e) <<< 1;
			swap = (seg_x0 > seg_x1);
			dir  = swap ? (seg_y0 > seg_y1) : (seg_y1 > seg_y0);
			cnt  = adx[CB-1:0];
		end else begin
			err  = (adx_e <<< 1) - ady_e;
			incs = adx_e <<< 1;
			incd = (adx_e - ady_e) <<< 1;
			swap = (seg_y0 > seg_y1);
			dir  = swap ? (seg_x0 > seg_x1) : (seg_x1 > seg_x0);
			cnt  = ady[CB-1:0];
		end
		sx  = swap ? seg_x1 : seg_x0;
		sy  = swap ? seg_y1 : seg_y0;
		cmd = {last_segment, dir, xmaj, incd, incs, err, cnt, probe_y, probe_x, sy, sx};
	end

endmodule

// ===== sv/pdist_fifo.sv =====
// Two-entry command queue between the front end and the walker.
module pdist_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ===== sv/pdist_walk.sv =====
// Back end: walks segment pixels, forms squared distance, keeps the running minimum.
module pdist_walk #(
	parameter int COORD_BITS = 12,
	parameter int CMD_BITS   = 8 * COORD_BITS + 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  logic [CMD_BITS-1:0]               cmd,
	output logic                              cmd_pop,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [pdist_pkg::DIST_BITS-1:0]   res_dist
);

	localparam int CB = COORD_BITS;
	localparam int EW = COORD_BITS + 3;
	localparam int DW = 2 * COORD_BITS + 2;
	localparam int SW = (DW > pdist_pkg::MIN_BITS) ? DW : pdist_pkg::MIN_BITS;

	// command fields
	logic signed [CB-1:0] c_sx, c_sy, c_qx, c_qy;
	logic [CB-1:0]        c_cnt;
	logic signed [EW-1:0] c_err, c_incs, c_incd;
	logic                 c_xmaj, c_dir, c_last;

	assign {c_last, c_dir, c_xmaj, c_incd, c_incs, c_err, c_cnt, c_qy, c_qx, c_sy, c_sx} = cmd;

	// walker state
	logic                 busy_q;
	logic signed [CB-1:0] cx_q, cy_q, qx_q, qy_q;
	logic [CB-1:0]        cnt_q;
	logic signed [EW-1:0] err_q, incs_q, incd_q;
	logic                 xmaj_q, dir_q, last_q;

	// distance pipeline
	logic                 v_s1, emit_s1, v_s2, emit_s2;
	logic signed [CB:0]   ex_s1, ey_s1;
	logic [2*CB:0]        sqx_s2, sqy_s2;
	logic signed [2*CB+1:0] px, py;

	logic [pdist_pkg::MIN_BITS-1:0]  min_q;
	logic                            out_valid_q;
	logic [pdist_pkg::DIST_BITS-1:0] out_data_q;

	logic                            adv, step_minor;
	logic [DW-1:0]                   sum;
	logic [SW-1:0]                   sum_w;
	logic [pdist_pkg::DIST_BITS-1:0] dist_clip;
	logic [pdist_pkg::MIN_BITS-1:0]  new_min;
	logic signed [CB-1:0]            minor_step;

	assign adv     = !(v_s2 && emit_s2 && out_valid_q && !res_ready);
	assign cmd_pop = cmd_valid && adv && (!busy_q || cnt_q == '0);

	assign res_valid = out_valid_q;
	assign res_dist  = out_data_q;

	always_comb begin
		step_minor = !err_q[EW-1];
		minor_step = dir_q ? CB'(1) : -CB'(1);
		px    = (2*CB+2)'(ex_s1) * (2*CB+2)'(ex_s1);
		py    = (2*CB+2)'(ey_s1) * (2*CB+2)'(ey_s1);
		sum   = DW'(sqx_s2) + DW'(sqy_s2);
		sum_w = SW'(sum);
		dist_clip = (sum_w > SW'(pdist_pkg::DIST_SAT)) ? pdist_pkg::DIST_SAT
		                                               : sum_w[pdist_pkg::DIST_BITS-1:0];
		new_min = ({1'b0, dist_clip} < min_q) ? {1'b0, dist_clip} : min_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			min_q       <= pdist_pkg::MIN_RESET;
		end else begin
			if (res_ready)
				out_valid_q <= 1'b0;
			if (adv) begin
				v_s1 <= busy_q;
				v_s2 <= v_s1;
				if (cmd_pop)
					busy_q <= 1'b1;
				else if (busy_q && cnt_q == '0)
					busy_q <= 1'b0;
				if (v_s2) begin
					if (emit_s2) begin
						out_valid_q <= 1'b1;
						min_q       <= pdist_pkg::MIN_RESET;
					end else begin
						min_q <= new_min;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s1   <= (CB+1)'(qx_q) - (CB+1)'(cx_q);
			ey_s1   <= (CB+1)'(qy_q) - (CB+1)'(cy_q);
			emit_s1 <= last_q && (cnt_q == '0);
			sqx_s2  <= px[2*CB:0];
			sqy_s2  <= py[2*CB:0];
			emit_s2 <= emit_s1;
			if (v_s2 && emit_s2)
				out_data_q <= new_min[pdist_pkg::DIST_BITS-1:0];
			if (cmd_pop) begin
				cx_q   <= c_sx;
				cy_q   <= c_sy;
				qx_q   <= c_qx;
				qy_q   <= c_qy;
				cnt_q  <= c_cnt;
				err_q  <= c_err;
				incs_q <= c_incs;
				incd_q <= c_incd;
				xmaj_q <= c_xmaj;
				dir_q  <= c_dir;
				last_q <= c_last;
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - CB'(1);
				err_q <= step_minor ? err_q + incd_q : err_q + incs_q;
				if (xmaj_q) begin
					cx_q <= cx_q + CB'(1);
					if (step_minor)
						cy_q <= cy_q + minor_step;
				end else begin
					cy_q <= cy_q + CB'(1);
					if (step_minor)
						cx_q <= cx_q + minor_step;
				end
			end
		end
	end

endmodule

// ===== sv/polyline_point_distance.sv =====
// The final pixel's distance passes the difference, square and output registers.
// Throughput: the walker visits one pixel per cycle unless the held output stalls it;
//   a segment has major-axis length + 1 pixels (up to 2^COORD_BITS); back-to-back segments overlap.
// A two-entry queue lets the front accept requests while the walker is busy.
// Reset (arst_n low, async): queue empty, walker idle, running minimum all ones.
// Output register holds a result until taken; the walker stalls behind it.
module polyline_point_distance #(
	parameter int COORD_BITS = 12
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// seg_x0, seg_y0, seg_x1, seg_y1, probe_x, probe_y (lowest bits first), zero pad
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]       s_tdata,
	// last_segment
	input  logic                                    s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// min_dist_sq, zero pad
	output logic [pdist_pkg::OUT_TDATA_BITS-1:0]    m_tdata
);

	localparam int CB       = COORD_BITS;
	localparam int CMD_BITS = 8 * COORD_BITS + 12;

	logic                 q_full, q_valid, q_pop, push;
	logic [CMD_BITS-1:0]  cmd_in, cmd_out;
	logic [pdist_pkg::DIST_BITS-1:0] min_dist;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;
	assign m_tdata  = pdist_pkg::OUT_TDATA_BITS'(min_dist);

	pdist_front #(.COORD_BITS(CB), .CMD_BITS(CMD_BITS)) u_front (
		.seg_x0       (s_tdata[CB-1:0]),
		.seg_y0       (s_tdata[2*CB-1:CB]),
		.seg_x1       (s_tdata[3*CB-1:2*CB]),
		.seg_y1       (s_tdata[4*CB-1:3*CB]),
		.probe_x      (s_tdata[5*CB-1:4*CB]),
		.probe_y      (s_tdata[6*CB-1:5*CB]),
		.last_segment (s_tuser),
		.cmd          (cmd_in)
	);

	pdist_fifo #(.WIDTH(CMD_BITS)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (cmd_out)
	);

	pdist_walk #(.COORD_BITS(CB), .CMD_BITS(CMD_BITS)) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (cmd_out),
		.cmd_pop   (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_dist  (min_dist)
	);

endmodule

// ===== verif/polyline_distance_checker.sv =====
// Checker for polyline_point_distance: predicts each shape's minimum squared distance and compares.
`timescale 1ns / 100ps
module polyline_distance_checker #(
	parameter int COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	// seg_x0, seg_y0, seg_x1, seg_y1, probe_x, probe_y (lowest bits first), zero pad
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	// last_segment
	input  logic                                 s_tuser,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	// min_dist_sq, zero pad
	input  logic [pdist_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   checked
);

	logic [pdist_pkg::DIST_BITS-1:0] expected_min_q[$];
	logic [pdist_pkg::MIN_BITS-1:0]  shape_min;
	int                              mismatches = 0;
	int                              n_checked = 0;

	function automatic int coord(input int k);
		return int'($signed(s_tdata[k*COORD_BITS +: COORD_BITS]));
	endfunction

	function automatic logic [pdist_pkg::DIST_BITS-1:0] pixel_dist_sq(
		input int px, py, qx, qy);
		longint ex, ey, s;
		ex = longint'(qx) - px;
		ey = longint'(qy) - py;
		s = ex * ex + ey * ey;
		return (s > longint'(pdist_pkg::DIST_SAT)) ? pdist_pkg::DIST_SAT
			: s[pdist_pkg::DIST_BITS-1:0];
	endfunction

	// Bresenham walk from the end with the smaller major coordinate; closest pixel wins.
	function automatic logic [pdist_pkg::DIST_BITS-1:0] walk_min_dist(
		input int ax, ay, bx, by, qx, qy);
		int adx, ady, len, nlen, err, cx, cy, ex, ey, step, k;
		bit xmajor;
		logic [pdist_pkg::DIST_BITS-1:0] best, d;
		adx = (bx > ax) ? bx - ax : ax - bx;
		ady = (by > ay) ? by - ay : ay - by;
		xmajor = (ady <= adx);
		len = xmajor ? adx : ady;
		nlen = xmajor ? ady : adx;
		if (xmajor ? (ax > bx) : (ay > by)) begin
			cx = bx; cy = by; ex = ax; ey = ay;
		end else begin
			cx = ax; cy = ay; ex = bx; ey = by;
		end
		if (xmajor)
			step = (ey > cy) ? 1 : -1;
		else
			step = (ex > cx) ? 1 : -1;
		err = 2 * nlen - len;
		best = pixel_dist_sq(cx, cy, qx, qy);
		for (k = 0; k < len; k++) begin
			if (xmajor)
				cx++;
			else
				cy++;
			if (err < 0) begin
				err += 2 * nlen;
			end else begin
				if (xmajor)
					cy += step;
				else
					cx += step;
				err += 2 * (nlen - len);
			end
			d = pixel_dist_sq(cx, cy, qx, qy);
			if (d < best)
				best = d;
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [pdist_pkg::DIST_BITS-1:0] seg_min, want, got;
		if (!arst_n) begin
			shape_min = pdist_pkg::MIN_RESET;
			expected_min_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[pdist_pkg::DIST_BITS-1:0];
				if (expected_min_q.size() == 0) begin
					$error("min_dist_sq: expected nothing, got %0d", got);
					mismatches++;
				end else begin
					want = expected_min_q.pop_front();
					n_checked++;
					if (got !== want) begin
						$error("min_dist_sq: expected %0d, got %0d", want, got);
						mismatches++;
					end
				end
				if (m_tdata[pdist_pkg::OUT_TDATA_BITS-1:pdist_pkg::DIST_BITS] !== '0) begin
					$error("m_tdata pad: expected 0, got %0h",
						m_tdata[pdist_pkg::OUT_TDATA_BITS-1:pdist_pkg::DIST_BITS]);
					mismatches++;
				end
			end
			if (s_tvalid && s_tready) begin
				seg_min = walk_min_dist(coord(0), coord(1), coord(2), coord(3),
					coord(4), coord(5));
				if ({1'b0, seg_min} < shape_min)
					shape_min = {1'b0, seg_min};
				if (s_tuser) begin
					expected_min_q.push_back(shape_min[pdist_pkg::DIST_BITS-1:0]);
					shape_min = pdist_pkg::MIN_RESET;
				end
			end
		end
		fail_count <= mismatches;
		pending <= expected_min_q.size();
		checked <= n_checked;
	end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for polyline_point_distance: reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_top;

	localparam int COORD_BITS = 12;
	localparam int S_TDATA_BITS = ((6*COORD_BITS+7)/8)*8;
	localparam int C_MIN = -(1 << (COORD_BITS-1));
	localparam int C_MAX = (1 << (COORD_BITS-1)) - 1;
	localparam int RANDOM_ITEMS = 110;
	localparam int HOLD_CYCLES = 500;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_tvalid;
	logic                                 s_tready;
	logic [S_TDATA_BITS-1:0]              s_tdata;
	logic                                 s_tuser;
	logic                                 m_tvalid;
	logic                                 m_tready;
	logic [pdist_pkg::OUT_TDATA_BITS-1:0] m_tdata;
	int                                   fail_count, pending, checked;
	int                                   n_sent = 0;
	int                                   n_shapes = 0;
	int                                   hold_req = 0;
	bit                                   quiet = 1'b0;

	polyline_point_distance #(.COORD_BITS(COORD_BITS)) dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata
	);

	polyline_distance_checker #(.COORD_BITS(COORD_BITS)) dist_check (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .fail_count, .pending, .checked
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int clamp_coord(input int v);
		return (v < C_MIN) ? C_MIN : ((v > C_MAX) ? C_MAX : v);
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(C_MAX - C_MIN)) + C_MIN;
	endfunction

	function automatic int near_coord(input int c, input int span);
		return clamp_coord(c + int'($urandom_range(2 * span)) - span);
	endfunction

	task automatic send_seg(input int x0, y0, x1, y1, qx, qy, input bit last);
		logic [S_TDATA_BITS-1:0] word;
		word = '0;
		word[0*COORD_BITS +: COORD_BITS] = x0[COORD_BITS-1:0];
		word[1*COORD_BITS +: COORD_BITS] = y0[COORD_BITS-1:0];
		word[2*COORD_BITS +: COORD_BITS] = x1[COORD_BITS-1:0];
		word[3*COORD_BITS +: COORD_BITS] = y1[COORD_BITS-1:0];
		word[4*COORD_BITS +: COORD_BITS] = qx[COORD_BITS-1:0];
		word[5*COORD_BITS +: COORD_BITS] = qy[COORD_BITS-1:0];
		while (!quiet && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
		if (last)
			n_shapes++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_seen, k;
		hold_seen = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else
				m_tready <= quiet || ($urandom_range(99) >= 29);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int x0, y0, x1, y1, qx, qy, sx, sy, nseg, k, n_random;
		bit prev_last;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, both axes, both directions, degenerate, multi-segment shapes
		send_seg(0, 0, 0, 0, 0, 0, 1'b1);
		send_seg(-2048, -2048, -2048, -2048, 2047, 2047, 1'b1);
		send_seg(-2048, -3, 2047, 5, 100, -2048, 1'b0);
		send_seg(40, 10, -30, -7, 5, 5, 1'b1);
		send_seg(3, -2048, -7, 2047, 2047, 0, 1'b1);
		send_seg(10, 50, 2, -60, -2048, 2047, 1'b1);
		send_seg(0, 0, 20, -5, 21, -6, 1'b0);
		send_seg(0, 0, -5, 20, -6, 21, 1'b1);
		send_seg(10, -10, -10, 10, 0, 3, 1'b1);
		send_seg(-50, 7, 50, 7, 0, -100, 1'b1);
		send_seg(7, 50, 7, -50, 2047, -2048, 1'b1);
		send_seg(2047, 2047, 2047, 2047, -2048, -2048, 1'b1);
		send_seg(0, 0, 30, 12, 15, 40, 1'b0);
		send_seg(30, 12, -8, 33, 15, 40, 1'b0);
		send_seg(-8, 33, 0, 0, 15, 40, 1'b1);
		send_seg(2047, -2048, -2048, 2047, 0, 0, 1'b1);
		send_seg(5, 5, 6, 900, 6, 450, 1'b1);
		send_seg(-2048, 2047, -2047, 2046, -2048, 2047, 1'b1);
		send_seg(100, 100, 100, 100, 100, 100, 1'b0);
		send_seg(1000, 1000, 1000, 1000, -1000, 1000, 1'b1);

		// output held off while short shapes keep coming: the block must back up
		hold_req++;
		repeat (8) begin
			x0 = any_coord();
			y0 = any_coord();
			send_seg(x0, y0, near_coord(x0, 10), near_coord(y0, 10),
				near_coord(x0, 50), near_coord(y0, 50), 1'b1);
		end

		// random: mostly chained polylines near a probe, some noise and long walks
		n_random = 0;
		prev_last = 1'b1;
		while (n_random < RANDOM_ITEMS) begin
			quiet = (n_random >= 50) && (n_random < 85);
			if ($urandom_range(9) == 0) begin
				prev_last = $urandom_range(1);
				send_seg(any_coord(), any_coord(), any_coord(), any_coord(),
					any_coord(), any_coord(), prev_last);
				n_random++;
			end else begin
				nseg = $urandom_range(1, 6);
				sx = any_coord();
				sy = any_coord();
				x0 = sx;
				y0 = sy;
				if ($urandom_range(9) < 7) begin
					qx = near_coord(sx, 200);
					qy = near_coord(sy, 200);
				end else begin
					qx = any_coord();
					qy = any_coord();
				end
				for (k = 0; k < nseg; k++) begin
					if (k == nseg - 1 && nseg > 2 && $urandom_range(2) == 0) begin
						x1 = sx;
						y1 = sy;
					end else if ($urandom_range(19) == 0) begin
						x1 = any_coord();
						y1 = any_coord();
					end else begin
						x1 = near_coord(x0, 60);
						y1 = near_coord(y0, 60);
					end
					if ($urandom_range(4) == 0) begin
						qx = near_coord(qx, 30);
						qy = near_coord(qy, 30);
					end
					prev_last = (k == nseg - 1);
					send_seg(x0, y0, x1, y1, qx, qy, prev_last);
					x0 = x1;
					y0 = y1;
				end
				n_random += nseg;
			end
		end
		quiet = 1'b0;
		if (!prev_last)
			send_seg(0, 0, 0, 0, 0, 0, 1'b1);
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d segment requests in %0d shapes, %0d distances checked",
			n_sent, n_shapes, checked);
		$display("tb_top: both walk axes and directions, full-range walks, %0d-cycle hold-off",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== polyline_point_distance.f =====
sv/pdist_pkg.sv
sv/pdist_front.sv
sv/pdist_fifo.sv
sv/pdist_walk.sv
sv/polyline_point_distance.sv
verif/polyline_distance_checker.sv
verif/tb_top.sv
